// ----- src/relr_pkg.sv -----
package relr_pkg;

  localparam int unsigned WORD_W       = 64;
  localparam int unsigned BITMAP_SLOTS = 63;
  localparam int unsigned SLOT_CNT_W   = $clog2(BITMAP_SLOTS);
  localparam logic [WORD_W-1:0] WORD_BYTES = WORD_W'(8);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADV,
    ST_SCAN
  } relr_state_t;

endpackage

// ----- src/relr_relocation_decoder_unit.sv -----
// Decoder for compact relative relocation words, one 64-bit word per input transaction.
// Input channel in_*: tdata carries the relocation word. Bit 0 clear marks an address entry,
// bit 0 set marks a bitmap.
// Result channel out_*: tdata is the absolute address to patch, tlast marks the final result
// of one input word, and tuser flags a bitmap that arrived before any address entry.
// cfg_wr_en / cfg_wr_data load the image base; write it only while the block is idle.
// Datapath: all sums go through one 64-bit adder under a small sequencer.
//   address entry: the result is registered in the accept cycle, and the ST_ADV state
//     that follows adds 8 to form the next location.
//   orphan bitmap: gives one flagged result.
//   bitmap with anchor: the accept cycle and then one bit position per cycle while the
//     output is not stalled. Each step adds 8 to the running location, and every set bit
//     yields a result on its own step.
// A new word is accepted only when the sequencer is idle and the output register is free
// or being drained. When the receiver stalls, the scan holds on a set bit until the output
// register frees up.
// Reset clears the image base, the next location and the anchor flag, and empties the
// output register.
module relr_relocation_decoder_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [relr_pkg::WORD_W-1:0]  in_tdata,    // relr_word
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [relr_pkg::WORD_W-1:0]  out_tdata,   // patch_address
  output logic                         out_tlast,   // last_of_word
  output logic                         out_tuser,   // orphan_bitmap
  input  logic                         cfg_wr_en,
  input  logic [relr_pkg::WORD_W-1:0]  cfg_wr_data  // image_base
);
  import relr_pkg::*;

  relr_state_t                  state_r, state_nxt;
  logic [WORD_W-1:0]            image_base_r;
  logic [WORD_W-1:0]            loc_r, loc_nxt;
  logic                         anchor_r, anchor_nxt;
  logic [BITMAP_SLOTS-1:0]      bits_r, bits_nxt;
  logic [SLOT_CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]            out_addr_r, out_addr_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_orphan_r, out_orphan_nxt;

  logic [WORD_W-1:0]            add_a, add_b, add_sum;
  logic                         out_free;
  logic                         in_acc;
  logic                         step;

  // shared adder: image base + word when idle, location + 8 otherwise
  assign add_a   = (state_r == ST_IDLE) ? image_base_r : loc_r;
  assign add_b   = (state_r == ST_IDLE) ? in_tdata : WORD_BYTES;
  assign add_sum = add_a + add_b;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign step      = !bits_r[0] || out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_orphan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      image_base_r <= '0;
      loc_r        <= '0;
      anchor_r     <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loc_r       <= loc_nxt;
      anchor_r    <= anchor_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        image_base_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    bits_r       <= bits_nxt;
    out_addr_r   <= out_addr_nxt;
    out_last_r   <= out_last_nxt;
    out_orphan_r <= out_orphan_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    loc_nxt        = loc_r;
    anchor_nxt     = anchor_r;
    bits_nxt       = bits_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_addr_nxt   = out_addr_r;
    out_last_nxt   = out_last_r;
    out_orphan_nxt = out_orphan_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_tdata[0]) begin
            out_valid_nxt  = 1'b1;
            out_addr_nxt   = add_sum;
            out_last_nxt   = 1'b1;
            out_orphan_nxt = 1'b0;
            loc_nxt        = add_sum;
            anchor_nxt     = 1'b1;
            state_nxt      = ST_ADV;
          end else if (!anchor_r) begin
            out_valid_nxt  = 1'b1;
            out_addr_nxt   = '0;
            out_last_nxt   = 1'b1;
            out_orphan_nxt = 1'b1;
          end else begin
            bits_nxt  = in_tdata[WORD_W-1:1];
            cnt_nxt   = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_ADV: begin
        loc_nxt   = add_sum;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (step) begin
          if (bits_r[0]) begin
            out_valid_nxt  = 1'b1;
            out_addr_nxt   = loc_r;
            // last when no higher bit is left in the bitmap
            out_last_nxt   = (bits_r[BITMAP_SLOTS-1:1] == '0);
            out_orphan_nxt = 1'b0;
          end
          loc_nxt  = add_sum;
          bits_nxt = {1'b0, bits_r[BITMAP_SLOTS-1:1]};
          cnt_nxt  = cnt_r + SLOT_CNT_W'(1);
          if (cnt_r == SLOT_CNT_W'(BITMAP_SLOTS - 1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> state_r == ST_IDLE)
    else $error("input accepted while sequencer busy");

  a_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_orphan_r |-> out_last_r && out_addr_r == '0)
    else $error("orphan result must be last with zero address");

  a_addr_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_tdata[0] |=> state_r == ST_ADV && anchor_r &&
      loc_r == $past(image_base_r + in_tdata))
    else $error("address entry did not set the location");

  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && step && cnt_r == SLOT_CNT_W'(BITMAP_SLOTS - 1)
      |=> state_r == ST_IDLE)
    else $error("bitmap scan did not finish after all slots");

  a_anchor_holds: assert property (@(posedge clk) disable iff (!rst_n)
    anchor_r |=> anchor_r)
    else $error("anchor lost without reset");

endmodule
